/* hw/rtl/dps_pkg.sv */
// Shared types for the dynamic priority scheduler: item and result beats,
// the slot table entry and the controller-to-datapath command group.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package dps_pkg;

	typedef struct packed {
		logic              kind;
		logic [2:0]        entry_slot;
		logic signed [7:0] start_priority;
		logic [7:0]        required_time;
	} item_t;

	typedef struct packed {
		logic       served;
		logic [2:0] served_slot;
		logic [7:0] allocated_time;
		logic [7:0] remaining_time;
		logic       finished;
		logic       all_idle;
	} result_t;

	typedef struct packed {
		logic signed [7:0] prio;
		logic [7:0]        remaining;
		logic [7:0]        allocated;
	} slot_entry_t;

	typedef struct packed {
		logic latch_item;
		logic clr_best;
		logic do_load;
		logic scan_rd;
		logic do_update;
		logic push;
	} cmd_t;

	localparam logic KIND_LOAD = 1'b0;
	localparam logic KIND_TICK = 1'b1;

	localparam logic signed [7:0] PRIO_FLOOR = 8'sh80;
	localparam logic [7:0]        ALLOC_CEIL = 8'hff;

endpackage

`default_nettype wire

/* hw/rtl/dps_ctrl.sv */
// Controller for the dynamic priority scheduler: sequences load, slot scan,
// update and result push. Depends on dps_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dps_ctrl
	import dps_pkg::*;
#(
	parameter int SLOTS = 8,
	parameter int IDX_W = 3
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             item_valid,
	input  wire logic             item_kind,
	output logic                  item_ready,
	output logic                  result_valid,
	input  wire logic             result_ready,
	output cmd_t                  cmd,
	output logic [IDX_W-1:0]      scan_idx
);

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_LOAD   = 3'd1;
	localparam logic [2:0] ST_SCAN   = 3'd2;
	localparam logic [2:0] ST_DRAIN  = 3'd3;
	localparam logic [2:0] ST_UPDATE = 3'd4;
	localparam logic [2:0] ST_PUSH   = 3'd5;

	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);
	localparam logic [IDX_W-1:0] IDX_ONE  = IDX_W'(1);

	logic [2:0]       state_q, state_d;
	logic [IDX_W-1:0] scan_idx_q;
	logic             out_valid_q;
	logic             accept;
	logic             out_free;

	assign accept   = item_valid && item_ready;
	assign out_free = !out_valid_q || result_ready;

	always_comb begin
		state_d    = state_q;
		item_ready = 1'b0;
		cmd        = '0;
		case (state_q)
			ST_IDLE: begin
				item_ready = 1'b1;
				if (item_valid) begin
					cmd.latch_item = 1'b1;
					cmd.clr_best   = 1'b1;
					state_d = (item_kind == KIND_TICK) ? ST_SCAN : ST_LOAD;
				end
			end
			ST_LOAD: begin
				cmd.do_load = 1'b1;
				state_d = ST_PUSH;
			end
			ST_SCAN: begin
				cmd.scan_rd = 1'b1;
				if (scan_idx_q == LAST_IDX) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				// last read beat is compared here
				state_d = ST_UPDATE;
			end
			ST_UPDATE: begin
				cmd.do_update = 1'b1;
				state_d = ST_PUSH;
			end
			ST_PUSH: begin
				if (out_free) begin
					cmd.push = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			scan_idx_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				scan_idx_q <= '0;
			end else if (cmd.scan_rd && scan_idx_q != LAST_IDX) begin
				scan_idx_q <= scan_idx_q + IDX_ONE;
			end
			if (cmd.push) begin
				out_valid_q <= 1'b1;
			end else if (result_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign scan_idx     = scan_idx_q;
	assign result_valid = out_valid_q;

endmodule

`default_nettype wire

/* hw/rtl/dps_datapath.sv */
// Datapath for the dynamic priority scheduler: slot table memory, active
// bits, running best-slot compare, slot update and result registers.
// Depends on dps_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dps_datapath
	import dps_pkg::*;
#(
	parameter int SLOTS = 8,
	parameter int IDX_W = 3
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire cmd_t             cmd,
	input  wire logic [IDX_W-1:0] scan_idx,
	input  wire item_t            item,
	output result_t               result
);

	slot_entry_t mem_q [SLOTS];

	item_t            item_q;
	logic [SLOTS-1:0] active_q, active_nx;

	logic             rd_vld_s1;
	logic [IDX_W-1:0] rd_idx_s1;
	slot_entry_t      rdata_s1;

	logic             best_found_q;
	logic [IDX_W-1:0] best_idx_q;
	slot_entry_t      best_q;

	result_t res_q, res_d;
	result_t result_q;

	logic [IDX_W+2:0] load_wide;
	logic [IDX_W-1:0] load_idx;
	logic             load_ok;
	logic [IDX_W+2:0] best_wide;
	logic             take_rd;

	slot_entry_t upd_entry;
	logic        upd_finished;

	logic             we;
	logic [IDX_W-1:0] waddr;
	slot_entry_t      wdata;

	assign load_wide = {{IDX_W{1'b0}}, item_q.entry_slot};
	assign load_idx  = load_wide[IDX_W-1:0];
	assign load_ok   = int'(item_q.entry_slot) < SLOTS;
	assign best_wide = {3'b000, best_idx_q};

	// strict greater keeps the lowest slot on a tie
	assign take_rd = rd_vld_s1 && active_q[rd_idx_s1]
		&& (!best_found_q || rdata_s1.prio > best_q.prio);

	always_comb begin
		upd_entry.allocated = (best_q.allocated == ALLOC_CEIL) ? ALLOC_CEIL
			: best_q.allocated + 8'd1;
		upd_entry.remaining = (best_q.remaining != 8'd0) ? best_q.remaining - 8'd1
			: 8'd0;
		upd_entry.prio      = (best_q.prio == PRIO_FLOOR) ? PRIO_FLOOR
			: best_q.prio - 8'sd1;
		upd_finished        = upd_entry.remaining == 8'd0;
	end

	always_comb begin
		active_nx = active_q;
		we        = 1'b0;
		waddr     = best_idx_q;
		wdata     = upd_entry;
		if (cmd.do_load && load_ok) begin
			active_nx[load_idx] = item_q.required_time != 8'd0;
			we    = 1'b1;
			waddr = load_idx;
			wdata = '{prio: item_q.start_priority, remaining: item_q.required_time,
				allocated: 8'd0};
		end
		if (cmd.do_update && best_found_q) begin
			we = 1'b1;
			if (upd_finished) begin
				active_nx[best_idx_q] = 1'b0;
			end
		end
	end

	always_comb begin
		res_d          = '0;
		res_d.all_idle = ~|active_nx;
		if (cmd.do_update && best_found_q) begin
			res_d.served         = 1'b1;
			res_d.served_slot    = best_wide[2:0];
			res_d.allocated_time = upd_entry.allocated;
			res_d.remaining_time = upd_entry.remaining;
			res_d.finished       = upd_finished;
		end
	end

	// slot table: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (cmd.scan_rd) begin
			rdata_s1 <= mem_q[scan_idx];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q     <= '0;
			rd_vld_s1    <= 1'b0;
			best_found_q <= 1'b0;
		end else begin
			active_q  <= active_nx;
			rd_vld_s1 <= cmd.scan_rd;
			if (cmd.clr_best) begin
				best_found_q <= 1'b0;
			end else if (take_rd) begin
				best_found_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		rd_idx_s1 <= scan_idx;
		if (cmd.latch_item) begin
			item_q <= item;
		end
		if (take_rd) begin
			best_idx_q <= rd_idx_s1;
			best_q     <= rdata_s1;
		end
		if (cmd.do_load || cmd.do_update) begin
			res_q <= res_d;
		end
		if (cmd.push) begin
			result_q <= res_q;
		end
	end

	assign result = result_q;

endmodule

`default_nettype wire

/* hw/rtl/dynamic_priority_scheduler.sv */
// Channel | Handshake                  | Payload
// item    | item_valid / item_ready    | item   (item_t: load or tick)
// result  | result_valid / result_ready| result (result_t: one per item)
//
// A load passes through load and push; a tick scans the slot table through its
// single read port, one slot a cycle, then drains, updates and pushes. Reset
// (arst_n low) clears the active bits, so every slot is inactive.
// The result register holds a beat while result_ready is low; the next item is
// still taken and worked, and waits in a staging register until the beat leaves.
// Top level of the dynamic priority scheduler; depends on dps_pkg, dps_ctrl,
// dps_datapath.
`timescale 1ns / 1ps
`default_nettype none

module dynamic_priority_scheduler
	import dps_pkg::*;
#(
	parameter int SLOTS = 8
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic item_valid,
	output logic      item_ready,
	input  wire item_t item,
	output logic      result_valid,
	input  wire logic result_ready,
	output result_t   result
);

	localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

	cmd_t             cmd;
	logic [IDX_W-1:0] scan_idx;

	dps_ctrl #(
		.SLOTS(SLOTS),
		.IDX_W(IDX_W)
	) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.item_valid  (item_valid),
		.item_kind   (item.kind),
		.item_ready  (item_ready),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.cmd         (cmd),
		.scan_idx    (scan_idx)
	);

	dps_datapath #(
		.SLOTS(SLOTS),
		.IDX_W(IDX_W)
	) u_datapath (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.scan_idx(scan_idx),
		.item    (item),
		.result  (result)
	);

endmodule

`default_nettype wire

/* hw/rtl/dps_checker.sv */
// Port-level checks for the dynamic priority scheduler, bound to the top level.
// Depends on dps_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dps_checker
	import dps_pkg::*;
(
	input wire logic    clk,
	input wire logic    arst_n,
	input wire logic    item_valid,
	input wire logic    item_ready,
	input wire logic    result_valid,
	input wire logic    result_ready,
	input wire result_t result
);

	// a stalled result beat holds
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(result))
		else $error("result beat changed while stalled");

	// one item in flight: no accept right after an accept
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_ready |=> !item_ready)
		else $error("item taken while previous still in work");

	a_unserved_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.served |-> result.served_slot == 3'd0
			&& result.allocated_time == 8'd0 && result.remaining_time == 8'd0
			&& !result.finished)
		else $error("unserved result carries slot data");

	a_finished: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.finished |-> result.served
			&& result.remaining_time == 8'd0)
		else $error("finished without a served slot at zero");

	a_served_alloc: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.served |-> result.allocated_time != 8'd0)
		else $error("served slot with no allocated time");

endmodule

bind dynamic_priority_scheduler dps_checker u_dps_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.item_valid  (item_valid),
	.item_ready  (item_ready),
	.result_valid(result_valid),
	.result_ready(result_ready),
	.result      (result)
);

`default_nettype wire

/* bench/tb_dynamic_priority_scheduler.sv */
// Testbench for dynamic_priority_scheduler: directed loads and ticks, then random
// job mixes under three idling phases, each result checked against an in-bench
// model of the slot table. Depends on dps_pkg and the scheduler RTL.
`timescale 1ns / 1ps

module tb_dynamic_priority_scheduler;
	import dps_pkg::*;

	localparam int SLOTS      = 8;
	localparam int CYCLE_CAP  = 1_000_000;
	localparam int HOLD_LEN   = 300;
	localparam int TAIL       = 2 * (SLOTS + 4);
	localparam int PHASE_ITEMS = 400;

	logic    clk          = 1'b0;
	logic    arst_n       = 1'b0;
	logic    item_valid   = 1'b0;
	logic    item_ready;
	item_t   item         = '0;
	logic    result_valid;
	logic    result_ready = 1'b0;
	result_t result;

	dynamic_priority_scheduler #(.SLOTS(SLOTS)) u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

	always #5 clk = ~clk;

	// slot table as the scheduler should hold it
	logic signed [7:0] tbl_prio  [SLOTS];
	logic [7:0]        tbl_left  [SLOTS];
	logic [7:0]        tbl_given [SLOTS];
	logic              tbl_live  [SLOTS];

	item_t   item_backlog [$];
	result_t outcome_q    [$];

	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int hold_reqs     = 0;
	int hold_taken    = 0;
	int hold_left     = 0;
	int errors        = 0;
	int cycle_count   = 0;

	function automatic result_t schedule_outcome(item_t it);
		result_t r;
		int      best;
		int      s;
		r    = '0;
		best = -1;
		if (it.kind == KIND_LOAD) begin
			s = int'(it.entry_slot);
			if (s < SLOTS) begin
				tbl_prio[s]  = it.start_priority;
				tbl_left[s]  = it.required_time;
				tbl_given[s] = '0;
				tbl_live[s]  = (it.required_time != 0);
			end
		end else begin
			for (int i = 0; i < SLOTS; i++) begin
				if (tbl_live[i] && (best < 0 || tbl_prio[i] > tbl_prio[best]))
					best = i;
			end
			if (best >= 0) begin
				if (tbl_given[best] != ALLOC_CEIL)
					tbl_given[best] = tbl_given[best] + 8'd1;
				if (tbl_left[best] != 0)
					tbl_left[best] = tbl_left[best] - 8'd1;
				if (tbl_prio[best] != PRIO_FLOOR)
					tbl_prio[best] = tbl_prio[best] - 8'sd1;
				if (tbl_left[best] == 0) begin
					tbl_live[best] = 1'b0;
					r.finished     = 1'b1;
				end
				r.served         = 1'b1;
				r.served_slot    = best[2:0];
				r.allocated_time = tbl_given[best];
				r.remaining_time = tbl_left[best];
			end
		end
		r.all_idle = 1'b1;
		for (int i = 0; i < SLOTS; i++) begin
			if (tbl_live[i])
				r.all_idle = 1'b0;
		end
		return r;
	endfunction

	function automatic void flag_field(string name, int unsigned want, int unsigned got);
		if (want != got) begin
			$display("%0t: result.%s mismatch: expected %0d, got %0d", $time, name, want, got);
			errors++;
		end
	endfunction

	task automatic queue_item(logic k, int s, logic [7:0] p, logic [7:0] t);
		item_t it;
		it.kind           = k;
		it.entry_slot     = s[2:0];
		it.start_priority = p;
		it.required_time  = t;
		item_backlog.push_back(it);
	endtask

	// a few loads with random content followed by a run of ticks, now and then noise
	task automatic queue_job_mix(output int n);
		int loads;
		int ticks;
		int r;
		int t;
		loads = $urandom_range(1, 6);
		ticks = $urandom_range(1, 24);
		n     = 0;
		for (int i = 0; i < loads; i++) begin
			r = $urandom_range(9);
			if (r == 0)
				t = 0;
			else if (r < 8)
				t = $urandom_range(1, 6);
			else
				t = $urandom_range(255);
			queue_item(KIND_LOAD, int'($urandom_range(SLOTS - 1)), 8'($urandom), 8'(t));
			n++;
		end
		for (int i = 0; i < ticks; i++) begin
			queue_item(KIND_TICK, int'($urandom_range(7)), 8'($urandom), 8'($urandom));
			n++;
		end
		if ($urandom_range(5) == 0) begin
			r = $urandom_range(1, 4);
			for (int i = 0; i < r; i++) begin
				queue_item(1'($urandom), int'($urandom), 8'($urandom), 8'($urandom));
				n++;
			end
		end
	endtask

	// one job run from full need to retirement, alone in the table
	task automatic queue_long_job();
		for (int i = 0; i < SLOTS; i++)
			queue_item(KIND_LOAD, i, 8'($urandom), 8'd0);
		queue_item(KIND_LOAD, int'($urandom_range(SLOTS - 1)), 8'($urandom), 8'd255);
		for (int i = 0; i < 257; i++)
			queue_item(KIND_TICK, int'($urandom_range(7)), 8'($urandom), 8'($urandom));
	endtask

	task automatic wait_drained();
		do
			@(negedge clk);
		while (item_backlog.size() != 0 || item_valid || outcome_q.size() != 0);
	endtask

	// item driver
	always @(posedge clk or negedge arst_n) begin
		logic  offer;
		item_t nxt;
		if (!arst_n) begin
			item_valid <= 1'b0;
			item       <= '0;
		end else begin
			if (item_valid && item_ready)
				outcome_q.push_back(schedule_outcome(item));
			if (!item_valid || item_ready) begin
				offer = (item_backlog.size() != 0) && ($urandom_range(99) >= send_idle_pct);
				if (offer) begin
					nxt = item_backlog.pop_front();
					item <= nxt;
				end
				item_valid <= offer;
			end
		end
	end

	// result monitor
	always @(posedge clk or negedge arst_n) begin
		result_t want;
		if (!arst_n) begin
			result_ready <= 1'b0;
		end else begin
			if (result_valid && result_ready) begin
				if (outcome_q.size() == 0) begin
					$display("%0t: unexpected result beat %p", $time, result);
					errors++;
				end else begin
					want = outcome_q.pop_front();
					flag_field("served", 32'(want.served), 32'(result.served));
					flag_field("served_slot", 32'(want.served_slot),
						32'(result.served_slot));
					flag_field("allocated_time", 32'(want.allocated_time),
						32'(result.allocated_time));
					flag_field("remaining_time", 32'(want.remaining_time),
						32'(result.remaining_time));
					flag_field("finished", 32'(want.finished), 32'(result.finished));
					flag_field("all_idle", 32'(want.all_idle), 32'(result.all_idle));
				end
			end
			if (hold_taken < hold_reqs) begin
				hold_left  = HOLD_LEN;
				hold_taken = hold_taken + 1;
			end
			if (hold_left > 0) begin
				hold_left = hold_left - 1;
				result_ready <= 1'b0;
			end else begin
				result_ready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_CAP) begin
			$display("tb_dynamic_priority_scheduler NOT OK");
			$finish;
		end
	end

	initial begin
		int n;
		int queued;
		for (int i = 0; i < SLOTS; i++) begin
			tbl_prio[i]  = '0;
			tbl_left[i]  = '0;
			tbl_given[i] = '0;
			tbl_live[i]  = 1'b0;
		end
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: empty table, tie on the floor, zero need, overwrite, floor reach
		queue_item(KIND_TICK, 0, 8'h00, 8'h00);
		queue_item(KIND_LOAD, 0, 8'h7f, 8'd1);
		queue_item(KIND_TICK, 0, 8'h00, 8'h00);
		queue_item(KIND_LOAD, 7, 8'h80, 8'd3);
		queue_item(KIND_LOAD, 3, 8'h80, 8'd2);
		queue_item(KIND_LOAD, 5, 8'h64, 8'd0);
		queue_item(KIND_TICK, 0, 8'h00, 8'h00);
		queue_item(KIND_TICK, 7, 8'hff, 8'hff);
		queue_item(KIND_TICK, 0, 8'h00, 8'h00);
		queue_item(KIND_LOAD, 7, 8'h80, 8'd255);
		queue_item(KIND_LOAD, 1, 8'h81, 8'd2);
		queue_item(KIND_TICK, 0, 8'h00, 8'h00);
		queue_item(KIND_TICK, 0, 8'h00, 8'h00);
		queue_item(KIND_TICK, 0, 8'h00, 8'h00);
		queue_item(KIND_LOAD, 7, 8'h00, 8'd0);
		queue_item(KIND_TICK, 0, 8'h00, 8'h00);
		queue_item(KIND_LOAD, 2, 8'h7f, 8'd255);
		queue_item(KIND_LOAD, 4, 8'h7e, 8'd255);
		queue_item(KIND_TICK, 0, 8'h00, 8'h00);
		queue_item(KIND_TICK, 0, 8'h00, 8'h00);
		queue_item(KIND_TICK, 0, 8'h00, 8'h00);
		queue_item(KIND_TICK, 0, 8'h00, 8'h00);
		wait_drained();

		for (int ph = 0; ph < 3; ph++) begin
			send_idle_pct = (ph == 0) ? 35 : (ph == 1) ? 59 : 0;
			recv_idle_pct = (ph == 0) ? 59 : (ph == 1) ? 35 : 0;
			if (ph == 2) begin
				hold_reqs = hold_reqs + 1;
				queue_long_job();
			end
			queued = 0;
			while (queued < PHASE_ITEMS) begin
				queue_job_mix(n);
				queued += n;
			end
			// sender stays quiet until every outstanding beat is back
			wait_drained();
		end

		repeat (TAIL) @(posedge clk);
		if (errors == 0)
			$display("tb_dynamic_priority_scheduler OK");
		else
			$display("tb_dynamic_priority_scheduler NOT OK");
		$finish;
	end

endmodule
